// File: hdl/wpsp_pkg.sv
// ----------------------------------------------------------------------------
// wpsp_pkg
// Shared widths, register codes and types of the screen projection block.
// ----------------------------------------------------------------------------
package wpsp_pkg;

  // Quotient bits kept by the divider: anything at or above 2^35 - 1
  // saturates the screen result, so this many bits decide every output.
  localparam int unsigned QW = 35;
  // Dividend |num| * size << 16 and divisor 2 * |w|.
  localparam int unsigned NW = 83;
  localparam int unsigned DW = 51;
  // One compare stage, then one stage per quotient bit.
  localparam int unsigned DIV_LAT = QW + 1;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_ROW0   = 3'd0;
  localparam logic [2:0] REG_ROW1   = 3'd1;
  localparam logic [2:0] REG_ROW2   = 3'd2;
  localparam logic [2:0] REG_ROW3   = 3'd3;
  localparam logic [2:0] REG_VSIZE  = 3'd4;
  localparam logic [2:0] REG_VORG   = 3'd5;
  localparam logic [2:0] REG_DEPTH  = 3'd6;

  // Per-word flags that ride alongside the divider.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic bad_w;
    logic outside;
  } side_t;

endpackage

// File: hdl/world_point_screen_projection.sv
// ----------------------------------------------------------------------------
// world_point_screen_projection
// Matrix transform, perspective divide and viewport mapping of one point.
// ----------------------------------------------------------------------------
// One point word is taken per cycle (busy stays low) and its result is
// flagged on done_o; words come out in order, one per cycle at full rate.
// Each word passes four stages of multiply, sum, sign split and scale, then
// the divider's compare stage plus one stage per quotient bit (35), then one
// output stage. The receiver cannot stall, so each result is valid for a
// single cycle. Reprogram registers only while no word is in flight.
module world_point_screen_projection #(
  parameter int unsigned MATRIX_FRAC = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] point_w_i,
  output logic               done_o,
  output logic signed [31:0] screen_x_o,
  output logic signed [31:0] screen_y_o,
  output logic               visible_o,
  output logic               outside_depth_o,
  output logic               bad_w_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  localparam int unsigned QW = wpsp_pkg::QW;
  localparam int unsigned NW = wpsp_pkg::NW;
  localparam int unsigned DW = wpsp_pkg::DW;
  localparam int unsigned DL = wpsp_pkg::DIV_LAT;

  // Configuration registers
  logic [63:0] row_q [4];
  logic [31:0] vsize_q;
  logic [31:0] vorg_q;
  logic [63:0] depth_q;
  logic [2:0]  reg_idx;

  assign reg_idx = paddr[5:3];
  assign pready  = 1'b1;
  assign busy    = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= 64'h0000_0000_0000_0100;
      row_q[1] <= 64'h0000_0000_0100_0000;
      row_q[2] <= 64'h0000_0100_0000_0000;
      row_q[3] <= 64'h0100_0000_0000_0000;
      vsize_q  <= 32'h01E0_0500;
      vorg_q   <= '0;
      depth_q  <= 64'h0001_0000_0000_0000;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        wpsp_pkg::REG_ROW0:  row_q[0] <= pwdata;
        wpsp_pkg::REG_ROW1:  row_q[1] <= pwdata;
        wpsp_pkg::REG_ROW2:  row_q[2] <= pwdata;
        wpsp_pkg::REG_ROW3:  row_q[3] <= pwdata;
        wpsp_pkg::REG_VSIZE: vsize_q  <= pwdata[31:0];
        wpsp_pkg::REG_VORG:  vorg_q   <= pwdata[31:0];
        wpsp_pkg::REG_DEPTH: depth_q  <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_idx)
      wpsp_pkg::REG_ROW0:  prdata = row_q[0];
      wpsp_pkg::REG_ROW1:  prdata = row_q[1];
      wpsp_pkg::REG_ROW2:  prdata = row_q[2];
      wpsp_pkg::REG_ROW3:  prdata = row_q[3];
      wpsp_pkg::REG_VSIZE: prdata = {32'b0, vsize_q};
      wpsp_pkg::REG_VORG:  prdata = {32'b0, vorg_q};
      wpsp_pkg::REG_DEPTH: prdata = depth_q;
      default:             prdata = '0;
    endcase
  end

  logic               accept;
  logic signed [31:0] pt [4];
  assign accept = start && !busy;
  assign pt[0]  = point_x_i;
  assign pt[1]  = point_y_i;
  assign pt[2]  = point_z_i;
  assign pt[3]  = point_w_i;

  // Valid bits of the front stages
  logic [3:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], accept};
    end
  end

  // Stage 1: sixteen products
  logic signed [47:0] prod_q [4][4];
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[i][k] <= pt[i] * $signed(row_q[i][16*k +: 16]);
      end
    end
  end

  // Stage 2: clip values
  logic signed [49:0] c_q [4];
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      c_q[k] <= 50'(prod_q[0][k]) + 50'(prod_q[1][k])
              + 50'(prod_q[2][k]) + 50'(prod_q[3][k]);
    end
  end

  // Stage 3: numerators, divisor, signs and depth test
  logic signed [50:0] numx_d, numy_d;
  logic signed [51:0] near_d, far_d, cz_d;
  logic [49:0]        magd_d;
  logic [50:0]        magx_q, magy_q;
  logic [DW-1:0]      d3_q;
  wpsp_pkg::side_t    side3_q;

  assign numx_d = 51'(c_q[0]) + 51'(c_q[3]);
  assign numy_d = 51'(c_q[3]) - 51'(c_q[1]);
  assign magd_d = c_q[3][49] ? 50'(-c_q[3]) : c_q[3];
  assign near_d = 52'($signed(depth_q[31:0])) <<< MATRIX_FRAC;
  assign far_d  = 52'($signed(depth_q[63:32])) <<< MATRIX_FRAC;
  assign cz_d   = 52'(c_q[2]);

  always_ff @(posedge clk_i) begin
    magx_q          <= numx_d[50] ? 51'(-numx_d) : numx_d;
    magy_q          <= numy_d[50] ? 51'(-numy_d) : numy_d;
    d3_q            <= {magd_d, 1'b0};
    side3_q.neg_x   <= numx_d[50] ^ c_q[3][49];
    side3_q.neg_y   <= numy_d[50] ^ c_q[3][49];
    side3_q.bad_w   <= (c_q[3] == '0);
    side3_q.outside <= (cz_d < near_d) || (cz_d > far_d);
  end

  // Stage 4: scale numerators by the viewport size
  logic [66:0]     px_q, py_q;
  logic [DW-1:0]   d4_q;
  wpsp_pkg::side_t side4_q;
  always_ff @(posedge clk_i) begin
    px_q    <= magx_q * vsize_q[15:0];
    py_q    <= magy_q * vsize_q[31:16];
    d4_q    <= d3_q;
    side4_q <= side3_q;
  end

  // Divide, flags delayed alongside
  logic          vx, vy;
  logic [QW-1:0] qx, qy;

  wpsp_div u_div_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (vld_q[3]),
    .n_i   (NW'({px_q, 16'b0})),
    .d_i   (d4_q),
    .vld_o (vx),
    .q_o   (qx)
  );

  wpsp_div u_div_y (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .vld_i (vld_q[3]),
    .n_i   (NW'({py_q, 16'b0})),
    .d_i   (d4_q),
    .vld_o (vy),
    .q_o   (qy)
  );

  wpsp_pkg::side_t side_q [DL];
  always_ff @(posedge clk_i) begin
    side_q[0] <= side4_q;
    for (int j = 1; j < DL; j++) begin
      side_q[j] <= side_q[j-1];
    end
  end

  // Output stage: sign, origin, saturate, bounds
  logic signed [36:0] sx_d, sy_d, ox_d, oy_d, wl_d, hl_d;
  logic               vis_d;
  localparam logic signed [36:0] SMAX = 37'sh0_7FFF_FFFF;
  localparam logic signed [36:0] SMIN = -37'sh0_8000_0000;

  assign ox_d = 37'($signed(vorg_q[15:0])) <<< 16;
  assign oy_d = 37'($signed(vorg_q[31:16])) <<< 16;
  assign wl_d = $signed({5'b0, vsize_q[15:0], 16'b0});
  assign hl_d = $signed({5'b0, vsize_q[31:16], 16'b0});
  assign sx_d = (side_q[DL-1].neg_x ? -$signed({2'b0, qx}) : $signed({2'b0, qx})) + ox_d;
  assign sy_d = (side_q[DL-1].neg_y ? -$signed({2'b0, qy}) : $signed({2'b0, qy})) + oy_d;
  assign vis_d = !(sx_d < 0 || sy_d < 0 || sx_d > wl_d || sy_d > hl_d
                   || side_q[DL-1].outside);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o <= 1'b0;
    end else begin
      done_o <= vx && vy;
    end
  end

  always_ff @(posedge clk_i) begin
    outside_depth_o <= side_q[DL-1].outside;
    bad_w_o         <= side_q[DL-1].bad_w;
    if (side_q[DL-1].bad_w) begin
      screen_x_o <= 32'sh7FFF_FFFF;
      screen_y_o <= 32'sh7FFF_FFFF;
      visible_o  <= 1'b0;
    end else begin
      screen_x_o <= (sx_d > SMAX) ? 32'sh7FFF_FFFF :
                    (sx_d < SMIN) ? 32'sh8000_0000 : sx_d[31:0];
      screen_y_o <= (sy_d > SMAX) ? 32'sh7FFF_FFFF :
                    (sy_d < SMIN) ? 32'sh8000_0000 : sy_d[31:0];
      visible_o  <= vis_d;
    end
  end

endmodule

// File: hdl/wpsp_div.sv
// ----------------------------------------------------------------------------
// wpsp_div
// Pipelined restoring divider, one quotient bit per stage, quotient saturated.
// ----------------------------------------------------------------------------
module wpsp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       vld_i,
  input  logic [wpsp_pkg::NW-1:0]    n_i,
  input  logic [wpsp_pkg::DW-1:0]    d_i,
  output logic                       vld_o,
  output logic [wpsp_pkg::QW-1:0]    q_o
);

  localparam int unsigned QW = wpsp_pkg::QW;
  localparam int unsigned DW = wpsp_pkg::DW;
  localparam int unsigned NW = wpsp_pkg::NW;
  localparam int unsigned HW = NW - QW;

  logic [QW:0]      vld_q;
  logic [DW-1:0]    r_q   [QW+1];
  logic [QW-1:0]    low_q [QW+1];
  logic [QW-1:0]    q_q   [QW+1];
  logic [DW-1:0]    d_q   [QW+1];
  logic             ov_q  [QW+1];

  logic [DW:0]      t_d   [QW];
  logic [DW:0]      sub_d [QW];
  logic             ge_d  [QW];

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QW-1:0], vld_i};
    end
  end

  // Trial subtract for each bit stage
  always_comb begin
    for (int j = 0; j < QW; j++) begin
      t_d[j]   = {r_q[j], low_q[j][QW-1]};
      sub_d[j] = t_d[j] - {1'b0, d_q[j]};
      ge_d[j]  = (t_d[j] >= {1'b0, d_q[j]});
    end
  end

  // Load the top part and flag overflow, then shift in one bit a stage
  always_ff @(posedge clk_i) begin
    r_q[0]   <= DW'(n_i[NW-1:QW]);
    low_q[0] <= n_i[QW-1:0];
    q_q[0]   <= '0;
    d_q[0]   <= d_i;
    ov_q[0]  <= ({{(DW-HW){1'b0}}, n_i[NW-1:QW]} >= d_i);
    for (int j = 1; j <= QW; j++) begin
      r_q[j]   <= ge_d[j-1] ? sub_d[j-1][DW-1:0] : t_d[j-1][DW-1:0];
      low_q[j] <= {low_q[j-1][QW-2:0], 1'b0};
      q_q[j]   <= {q_q[j-1][QW-2:0], ge_d[j-1]};
      d_q[j]   <= d_q[j-1];
      ov_q[j]  <= ov_q[j-1];
    end
  end

  assign vld_o = vld_q[QW];
  assign q_o   = ov_q[QW] ? '1 : q_q[QW];

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives points into the screen projection block at random rates, programs
// matrix, viewport and depth registers between phases, and checks every
// result word against a bit-accurate predictor of projection and divide.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned FRAC      = 8;
  localparam int unsigned LATENCY   = 41;
  localparam longint      CYCLE_CAP = 400000;

  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               vis;
    logic               outside;
    logic               bad_w;
  } screen_word_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic signed [31:0] point_x_i, point_y_i, point_z_i, point_w_i;
  logic               done_o;
  logic signed [31:0] screen_x_o, screen_y_o;
  logic               visible_o, outside_depth_o, bad_w_o;
  logic               psel, penable, pwrite;
  logic [5:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;

  // shadow copy of the configuration
  logic [63:0] row_q [4];
  logic [31:0] vsize_q;
  logic [31:0] vorg_q;
  logic [63:0] depth_q;

  screen_word_t pending_screen[$];
  int  mismatches;
  int  words_sent;
  int  words_checked;
  bit  quiet_phase;
  longint cycles;

  world_point_screen_projection #(.MATRIX_FRAC(FRAC)) u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .point_x_i, .point_y_i, .point_z_i, .point_w_i,
    .done_o, .screen_x_o, .screen_y_o, .visible_o, .outside_depth_o, .bad_w_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_CAP) begin
        $display("timeout after %0d cycles", cycles);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // quotient of a 128-bit dividend by d, truncated and capped at 2^62
  function automatic logic [63:0] capped_quotient(logic [127:0] n, logic [63:0] d);
    logic [127:0] q;
    q = n / d;
    if (q > (128'd1 << 62)) q = 128'd1 << 62;
    return q[63:0];
  endfunction

  // size * num / (2 * den) in Q16.16 plus origin, unsaturated
  function automatic longint map_axis(longint num, longint den, logic [15:0] size,
                                      logic signed [15:0] org);
    logic [63:0]  mn, md;
    logic [127:0] prod;
    longint s;
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    prod = 128'(mn) * (128'(size) << 16);
    s = longint'(capped_quotient(prod, md << 1));
    if ((num < 0) != (den < 0)) s = -s;
    return s + longint'(org) * 65536;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic screen_word_t project_point(logic signed [31:0] px,
      logic signed [31:0] py, logic signed [31:0] pz, logic signed [31:0] pw);
    screen_word_t r;
    longint p [4];
    longint c [4];
    longint near_v, far_v, sx, sy, wl, hl;
    logic signed [15:0] e;
    p[0] = px; p[1] = py; p[2] = pz; p[3] = pw;
    for (int k = 0; k < 4; k++) begin
      c[k] = 0;
      for (int i = 0; i < 4; i++) begin
        e = row_q[i][16*k +: 16];
        c[k] += p[i] * longint'(e);
      end
    end
    near_v = longint'($signed(depth_q[31:0])) * (64'sd1 << FRAC);
    far_v  = longint'($signed(depth_q[63:32])) * (64'sd1 << FRAC);
    r.outside = (c[2] < near_v) || (c[2] > far_v);
    if (c[3] == 0) begin
      r.sx = 32'sh7FFFFFFF;
      r.sy = 32'sh7FFFFFFF;
      r.vis = 1'b0;
      r.bad_w = 1'b1;
      return r;
    end
    wl = longint'(vsize_q[15:0]) << 16;
    hl = longint'(vsize_q[31:16]) << 16;
    sx = map_axis(c[0] + c[3], c[3], vsize_q[15:0], vorg_q[15:0]);
    sy = map_axis(c[3] - c[1], c[3], vsize_q[31:16], vorg_q[31:16]);
    r.vis = !(sx < 0 || sy < 0 || sx > wl || sy > hl || r.outside);
    r.sx = clamp32(sx);
    r.sy = clamp32(sy);
    r.bad_w = 1'b0;
    return r;
  endfunction

  // compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    screen_word_t got, want;
    if (rst_ni && done_o) begin
      got = '{screen_x_o, screen_y_o, visible_o, outside_depth_o, bad_w_o};
      if (pending_screen.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
        want = pending_screen.pop_front();
        words_checked++;
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h vis=%b out=%b bad=%b, got x=%h y=%h vis=%b out=%b bad=%b",
                     want.sx, want.sy, want.vis, want.outside, want.bad_w,
                     got.sx, got.sy, got.vis, got.outside, got.bad_w);
        end
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      wpsp_pkg::REG_ROW0, wpsp_pkg::REG_ROW1, wpsp_pkg::REG_ROW2,
      wpsp_pkg::REG_ROW3: row_q[idx[1:0]] = val;
      wpsp_pkg::REG_VSIZE: vsize_q = val[31:0];
      wpsp_pkg::REG_VORG:  vorg_q  = val[31:0];
      wpsp_pkg::REG_DEPTH: depth_q = val;
      default: ;
    endcase
  endtask

  // send one point word; start stays high across back-to-back words
  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                            logic [31:0] w);
    while (!quiet_phase && $urandom_range(0, 99) < 11) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    point_x_i <= x; point_y_i <= y; point_z_i <= z; point_w_i <= w;
    do @(posedge clk_i); while (busy);
    pending_screen.push_back(project_point(x, y, z, w));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_screen.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return $signed($urandom_range(0, 32'h000A0000)) - 32'sh00050000;
    endcase
  endfunction

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 1024)) - 512);
    endcase
  endfunction

  task automatic test_directed();
    logic [31:0] ext [6] = '{32'h0, 32'h7FFFFFFF, 32'h80000000, 32'h00010000,
                             32'hFFFF0000, 32'h00008000};
    send_point(32'h0, 32'h0, 32'h0, 32'h0);              // zero w
    send_point(32'h0, 32'h0, 32'h00008000, 32'h00010000); // screen center
    send_point(32'h00010000, 32'hFFFF0000, 32'h0, 32'h00010000); // corner
    send_point(32'h0, 32'h0, 32'h00020000, 32'h00010000); // beyond far
    send_point(32'h0, 32'h0, 32'hFFFF0000, 32'h00010000); // before near
    send_point(32'h0, 32'h0, 32'h0, 32'hFFFF0000);       // negative w
    send_point(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h00000001); // huge quotient
    for (int i = 0; i < 12; i++)
      send_point(ext[i % 6], ext[(i + 1) % 6], ext[(i + 2) % 6], ext[(i + 3) % 6]);
    drain();
  endtask

  task automatic test_extreme_config();
    write_reg(wpsp_pkg::REG_ROW0, 64'hFFFF_8000_7FFF_0100);
    write_reg(wpsp_pkg::REG_ROW1, 64'h8000_7FFF_0100_FFFF);
    write_reg(wpsp_pkg::REG_ROW2, 64'h7FFF_0100_FFFF_8000);
    write_reg(wpsp_pkg::REG_ROW3, 64'h0100_FFFF_8000_7FFF);
    write_reg(wpsp_pkg::REG_VSIZE, 64'h0000_0000_FFFF_FFFF);
    write_reg(wpsp_pkg::REG_VORG, 64'h0000_0000_8000_7FFF);
    write_reg(wpsp_pkg::REG_DEPTH, 64'h7FFFFFFF_80000000);
    for (int i = 0; i < 150; i++) send_point(rand_coord(), rand_coord(), rand_coord(),
                                             rand_coord());
    drain();
    write_reg(wpsp_pkg::REG_VSIZE, 64'h0);
    write_reg(wpsp_pkg::REG_VORG, 64'h0);
    write_reg(wpsp_pkg::REG_DEPTH, 64'h80000000_7FFFFFFF);
    for (int i = 0; i < 100; i++) send_point(rand_coord(), rand_coord(), rand_coord(),
                                             rand_coord());
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 10; ph++) begin
      quiet_phase = (ph == 3);
      for (int r = 0; r < 4; r++)
        write_reg(3'(r), {rand_entry(), rand_entry(), rand_entry(), rand_entry()});
      if (ph % 3 == 0) begin
        // row 3 made identity-like for w (optionally also feeding z) so clip w follows the point's w
        write_reg(wpsp_pkg::REG_ROW3,
                  {16'h0100, $urandom_range(0, 1) ? 16'h0100 : 16'h0, 32'h0});
      end
      write_reg(wpsp_pkg::REG_VSIZE, 64'($urandom_range(0, 3) == 0 ? $urandom :
                {16'($urandom_range(1, 2048)), 16'($urandom_range(1, 2048))}));
      write_reg(wpsp_pkg::REG_VORG, 64'($urandom_range(0, 1) ? $urandom : 32'(0)));
      write_reg(wpsp_pkg::REG_DEPTH,
                {32'($signed($urandom_range(0, 32'h40000)) - 32'sh10000),
                 32'($signed($urandom_range(0, 32'h20000)) - 32'sh18000)});
      for (int i = 0; i < 170; i++) send_point(rand_coord(), rand_coord(), rand_coord(),
                                               rand_coord());
      drain();
    end
    quiet_phase = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    point_x_i = '0; point_y_i = '0; point_z_i = '0; point_w_i = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    mismatches = 0; words_sent = 0; words_checked = 0; quiet_phase = 1'b0;
    row_q[0] = 64'd256;
    row_q[1] = 64'd16777216;
    row_q[2] = 64'd1099511627776;
    row_q[3] = 64'd72057594037927936;
    vsize_q = 32'd31458560;
    vorg_q = '0;
    depth_q = 64'd281474976710656;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    test_extreme_config();
    test_random_phases();

    $display("points sent: %0d, result words checked: %0d, mismatches: %0d",
             words_sent, words_checked, mismatches);
    $display("covered reset matrix, extreme registers and ten random settings");
    if (mismatches == 0 && pending_screen.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: world_point_screen_projection.f
hdl/wpsp_pkg.sv
hdl/wpsp_div.sv
hdl/world_point_screen_projection.sv
tb/tb_top.sv
